// ----- src/mfl_pkg.sv -----
// ----------------------------------------------------------------------------
// mfl_pkg
// Shared widths, register indexes, state and operation codes, and the
// status bundle of the level-graph maximum flow engine.
// ----------------------------------------------------------------------------
package mfl_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_CAP_BITS  = 16;

    localparam int NODE_W     = 6;
    localparam int CAP_IN_W   = 16;
    localparam int FLOW_OUT_W = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK       = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_NODE_COUNT = 7'd64;
    localparam logic [NODE_W-1:0]     RST_SOURCE     = 6'd0;
    localparam logic [NODE_W-1:0]     RST_SINK       = 6'd63;

    localparam logic REQ_RUN = 1'b1;

    localparam logic [FLOW_OUT_W-1:0] FLOW_OUT_MAX = 22'h3FFFFF;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR_CAP,
        ST_CLR_FLOW,
        ST_BFS_INIT,
        ST_BFS_POP,
        ST_BFS_LVL,
        ST_BFS_LVW,
        ST_BFS_RD,
        ST_BFS_EV,
        ST_BFS_END,
        ST_NX_CLR,
        ST_AUG_INIT,
        ST_AUG_NX,
        ST_AUG_SCAN,
        ST_AUG_EV,
        ST_PUSH,
        ST_POP,
        ST_POPV,
        ST_POPN,
        ST_BN_INIT,
        ST_BN_A,
        ST_BN_C,
        ST_BN_R,
        ST_UP_INIT,
        ST_UP_A,
        ST_UP_C,
        ST_UP_W1,
        ST_UP_W2,
        ST_ACC,
        ST_RESULT
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_TAKE_WR,
        OP_TAKE_RUN,
        OP_CLR_CAP,
        OP_CLR_FLOW,
        OP_BFS_INIT,
        OP_BFS_POP,
        OP_BFS_LVL,
        OP_BFS_LVW,
        OP_BFS_RD,
        OP_BFS_EV,
        OP_NX_START,
        OP_NX_CLR,
        OP_AUG_INIT,
        OP_AUG_NX,
        OP_AUG_SCAN,
        OP_AUG_SKIP,
        OP_PUSH,
        OP_POP,
        OP_POPV,
        OP_POPN,
        OP_BN_INIT,
        OP_BN_A,
        OP_BN_C,
        OP_BN_R,
        OP_UP_INIT,
        OP_UP_A,
        OP_UP_C,
        OP_UP_W1,
        OP_UP_W2,
        OP_ACC,
        OP_RESULT
    } op_t;

    typedef struct packed {
        logic clr_last;
        logic run_ok;
        logic head_eq_tail;
        logic scan_end;
        logic bfs_hit;
        logic nx_last;
        logic edge_ok;
        logic depth_room;
        logic nx_is_dst;
        logic bi_last;
        logic out_busy;
    } status_t;

endpackage

// ----- src/mfl_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfl_ctrl
// Sequencer of the engine: walks the clearing passes, the level search, the
// path search, the bottleneck and update passes, and issues one datapath
// operation per cycle.
// ----------------------------------------------------------------------------
module mfl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             req_type,
    input  mfl_pkg::status_t status,
    output mfl_pkg::op_t     op,
    output logic             in_stall
);
    import mfl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR_CAP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NOP;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (req_type == REQ_RUN)
                    begin
                        op         = OP_TAKE_RUN;
                        state_next = ST_CLR_FLOW;
                    end
                    else
                    begin
                        op = OP_TAKE_WR;
                    end
                end
            end
            ST_CLR_CAP:
            begin
                op = OP_CLR_CAP;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLR_FLOW:
            begin
                op = OP_CLR_FLOW;
                if (status.clr_last)
                begin
                    state_next = status.run_ok ? ST_BFS_INIT : ST_RESULT;
                end
            end
            ST_BFS_INIT:
            begin
                op         = OP_BFS_INIT;
                state_next = ST_BFS_POP;
            end
            ST_BFS_POP:
            begin
                if (status.head_eq_tail)
                begin
                    state_next = ST_BFS_END;
                end
                else
                begin
                    op         = OP_BFS_POP;
                    state_next = ST_BFS_LVL;
                end
            end
            ST_BFS_LVL:
            begin
                op         = OP_BFS_LVL;
                state_next = ST_BFS_LVW;
            end
            ST_BFS_LVW:
            begin
                op         = OP_BFS_LVW;
                state_next = ST_BFS_RD;
            end
            ST_BFS_RD:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_BFS_POP;
                end
                else
                begin
                    op         = OP_BFS_RD;
                    state_next = ST_BFS_EV;
                end
            end
            ST_BFS_EV:
            begin
                op         = OP_BFS_EV;
                state_next = ST_BFS_RD;
            end
            ST_BFS_END:
            begin
                if (status.bfs_hit)
                begin
                    op         = OP_NX_START;
                    state_next = ST_NX_CLR;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_NX_CLR:
            begin
                op = OP_NX_CLR;
                if (status.nx_last)
                begin
                    state_next = ST_AUG_INIT;
                end
            end
            ST_AUG_INIT:
            begin
                op         = OP_AUG_INIT;
                state_next = ST_AUG_NX;
            end
            ST_AUG_NX:
            begin
                op         = OP_AUG_NX;
                state_next = ST_AUG_SCAN;
            end
            ST_AUG_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    op         = OP_AUG_SCAN;
                    state_next = ST_AUG_EV;
                end
            end
            ST_AUG_EV:
            begin
                if (status.edge_ok)
                begin
                    state_next = status.depth_room ? ST_PUSH : ST_POP;
                end
                else
                begin
                    op         = OP_AUG_SKIP;
                    state_next = ST_AUG_SCAN;
                end
            end
            ST_PUSH:
            begin
                op         = OP_PUSH;
                state_next = status.nx_is_dst ? ST_BN_INIT : ST_AUG_NX;
            end
            ST_POP:
            begin
                op         = OP_POP;
                state_next = status.bi_last ? ST_BFS_INIT : ST_POPV;
            end
            ST_POPV:
            begin
                op         = OP_POPV;
                state_next = ST_POPN;
            end
            ST_POPN:
            begin
                op         = OP_POPN;
                state_next = ST_AUG_SCAN;
            end
            ST_BN_INIT:
            begin
                op         = OP_BN_INIT;
                state_next = ST_BN_A;
            end
            ST_BN_A:
            begin
                op         = OP_BN_A;
                state_next = ST_BN_C;
            end
            ST_BN_C:
            begin
                op         = OP_BN_C;
                state_next = ST_BN_R;
            end
            ST_BN_R:
            begin
                op         = OP_BN_R;
                state_next = status.bi_last ? ST_UP_INIT : ST_BN_C;
            end
            ST_UP_INIT:
            begin
                op         = OP_UP_INIT;
                state_next = ST_UP_A;
            end
            ST_UP_A:
            begin
                op         = OP_UP_A;
                state_next = ST_UP_C;
            end
            ST_UP_C:
            begin
                op         = OP_UP_C;
                state_next = ST_UP_W1;
            end
            ST_UP_W1:
            begin
                op         = OP_UP_W1;
                state_next = ST_UP_W2;
            end
            ST_UP_W2:
            begin
                op         = OP_UP_W2;
                state_next = status.bi_last ? ST_ACC : ST_UP_C;
            end
            ST_ACC:
            begin
                op         = OP_ACC;
                state_next = ST_AUG_INIT;
            end
            ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    op         = OP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/mfl_datapath.sv -----
// ----------------------------------------------------------------------------
// mfl_datapath
// Capacity and flow matrices, level, pointer, queue and path stores, the
// configuration registers and the result register. Executes one operation
// of the sequencer per cycle.
// ----------------------------------------------------------------------------
module mfl_datapath #(
    parameter int MAX_NODES = mfl_pkg::DEF_MAX_NODES,
    parameter int CAP_BITS  = mfl_pkg::DEF_CAP_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mfl_pkg::op_t                      op,
    output mfl_pkg::status_t                  status,
    input  logic [mfl_pkg::NODE_W-1:0]        from_node,
    input  logic [mfl_pkg::NODE_W-1:0]        to_node,
    input  logic [mfl_pkg::CAP_IN_W-1:0]      capacity,
    input  logic                              cfg_write,
    input  logic [mfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mfl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mfl_pkg::FLOW_OUT_W-1:0]    max_flow
);
    import mfl_pkg::*;

    localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int DEPTH  = MAX_NODES * MAX_NODES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FLOW_W = CAP_BITS + 1;
    localparam int RES_W  = CAP_BITS + 2;
    localparam int TOT_W  = ((CAP_BITS > FLOW_OUT_W) ? CAP_BITS : FLOW_OUT_W) + 1;
    localparam logic [CAP_BITS-1:0] CAP_MAX = {CAP_BITS{1'b1}};

    function automatic logic [ADDR_W-1:0] mat_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
        mat_addr = ADDR_W'(int'(r) * MAX_NODES + int'(c));
    endfunction

    logic [CAP_BITS-1:0]      cap_mem   [0:DEPTH-1];
    logic signed [FLOW_W-1:0] flow_mem  [0:DEPTH-1];
    logic [IDX_W-1:0]         level_mem [0:MAX_NODES-1];
    logic [CNT_W-1:0]         next_mem  [0:MAX_NODES-1];
    logic [IDX_W-1:0]         queue_mem [0:MAX_NODES-1];
    logic [IDX_W-1:0]         stack_mem [0:MAX_NODES-1];

    logic [CAP_BITS-1:0]      cap_rd_reg;
    logic signed [FLOW_W-1:0] flow_rd_reg;
    logic [IDX_W-1:0]         level_rd_reg;
    logic [CNT_W-1:0]         next_rd_reg;
    logic [IDX_W-1:0]         queue_rd_reg;
    logic [IDX_W-1:0]         stack_rd_reg;

    logic [CFG_DATA_W-1:0] node_count_reg, node_count_next;
    logic [NODE_W-1:0]     source_reg, source_next;
    logic [NODE_W-1:0]     sink_reg, sink_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [IDX_W-1:0]      src_reg, src_next;
    logic [IDX_W-1:0]      dst_reg, dst_next;
    logic                  run_ok_reg, run_ok_next;
    logic [ADDR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      tail_reg, tail_next;
    logic [IDX_W-1:0]      cur_v_reg, cur_v_next;
    logic [IDX_W-1:0]      cur_lvl_reg, cur_lvl_next;
    logic [CNT_W-1:0]      cur_nx_reg, cur_nx_next;
    logic [IDX_W-1:0]      depth_reg, depth_next;
    logic [IDX_W-1:0]      bi_reg, bi_next;
    logic [IDX_W-1:0]      a_reg, a_next;
    logic [IDX_W-1:0]      c_reg, c_next;
    logic [CAP_BITS-1:0]   b_reg, b_next;
    logic [FLOW_OUT_W-1:0] total_reg, total_next;
    logic [MAX_NODES-1:0]  lv_reg, lv_next;
    logic                  out_valid_reg, out_valid_next;
    logic [FLOW_OUT_W-1:0] out_data_reg, out_data_next;

    logic [ADDR_W-1:0]        mat_rd_addr;
    logic                     cap_we;
    logic [ADDR_W-1:0]        cap_wr_addr;
    logic [CAP_BITS-1:0]      cap_wr_data;
    logic                     flow_we;
    logic [ADDR_W-1:0]        flow_wr_addr;
    logic signed [FLOW_W-1:0] flow_wr_data;
    logic                     lvl_we;
    logic [IDX_W-1:0]         lvl_wr_addr;
    logic [IDX_W-1:0]         lvl_wr_data;
    logic [IDX_W-1:0]         lvl_rd_addr;
    logic                     nx_we;
    logic [IDX_W-1:0]         nx_wr_addr;
    logic [CNT_W-1:0]         nx_wr_data;
    logic [IDX_W-1:0]         nx_rd_addr;
    logic                     q_we;
    logic [IDX_W-1:0]         q_wr_addr;
    logic [IDX_W-1:0]         q_wr_data;
    logic [IDX_W-1:0]         q_rd_addr;
    logic                     stk_we;
    logic [IDX_W-1:0]         stk_wr_addr;
    logic [IDX_W-1:0]         stk_wr_data;
    logic [IDX_W-1:0]         stk_rd_addr;

    logic [CNT_W-1:0]        n_eff;
    logic                    run_ok_c;
    logic [IDX_W-1:0]        cur_idx;
    logic [IDX_W:0]          lvl_plus;
    logic signed [RES_W-1:0] res;
    logic                    res_pos;
    logic [CNT_W-1:0]        depth_p1;
    logic [TOT_W-1:0]        sum;

    assign cur_idx  = cur_nx_reg[IDX_W-1:0];
    assign lvl_plus = {1'b0, cur_lvl_reg} + (IDX_W + 1)'(1);
    assign res      = $signed({2'b00, cap_rd_reg}) - $signed({flow_rd_reg[FLOW_W-1], flow_rd_reg});
    assign res_pos  = !res[RES_W-1] && (res != '0);
    assign depth_p1 = CNT_W'(depth_reg) + CNT_W'(1);
    assign sum      = TOT_W'(total_reg) + TOT_W'(b_reg);

    always_comb
    begin
        if (node_count_reg < CFG_DATA_W'(2))
        begin
            n_eff = CNT_W'(2);
        end
        else if (int'(node_count_reg) > MAX_NODES)
        begin
            n_eff = CNT_W'(MAX_NODES);
        end
        else
        begin
            n_eff = CNT_W'(node_count_reg);
        end
        run_ok_c = (int'(source_reg) < int'(n_eff)) && (int'(sink_reg) < int'(n_eff)) &&
                   (source_reg != sink_reg);
    end

    assign status.clr_last     = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign status.run_ok       = run_ok_reg;
    assign status.head_eq_tail = (head_reg == tail_reg);
    assign status.scan_end     = (cur_nx_reg == n_reg);
    assign status.bfs_hit      = lv_reg[dst_reg];
    assign status.nx_last      = (clr_cnt_reg == ADDR_W'(n_reg - CNT_W'(1)));
    assign status.edge_ok      = lv_reg[cur_idx] && ({1'b0, level_rd_reg} == lvl_plus) && res_pos;
    assign status.depth_room   = (depth_p1 < n_reg);
    assign status.nx_is_dst    = (cur_idx == dst_reg);
    assign status.bi_last      = (bi_reg == depth_reg);
    assign status.out_busy     = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign max_flow  = out_data_reg;

    always_comb
    begin
        node_count_next = node_count_reg;
        source_next     = source_reg;
        sink_next       = sink_reg;
        n_next          = n_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        run_ok_next     = run_ok_reg;
        clr_cnt_next    = clr_cnt_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_v_next      = cur_v_reg;
        cur_lvl_next    = cur_lvl_reg;
        cur_nx_next     = cur_nx_reg;
        depth_next      = depth_reg;
        bi_next         = bi_reg;
        a_next          = a_reg;
        c_next          = c_reg;
        b_next          = b_reg;
        total_next      = total_reg;
        lv_next         = lv_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;

        mat_rd_addr  = '0;
        cap_we       = 1'b0;
        cap_wr_addr  = '0;
        cap_wr_data  = '0;
        flow_we      = 1'b0;
        flow_wr_addr = '0;
        flow_wr_data = '0;
        lvl_we       = 1'b0;
        lvl_wr_addr  = '0;
        lvl_wr_data  = '0;
        lvl_rd_addr  = '0;
        nx_we        = 1'b0;
        nx_wr_addr   = '0;
        nx_wr_data   = '0;
        nx_rd_addr   = '0;
        q_we         = 1'b0;
        q_wr_addr    = '0;
        q_wr_data    = '0;
        q_rd_addr    = '0;
        stk_we       = 1'b0;
        stk_wr_addr  = '0;
        stk_wr_data  = '0;
        stk_rd_addr  = '0;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_NODE_COUNT: node_count_next = cfg_data;
                CFG_SOURCE:     source_next     = cfg_data[NODE_W-1:0];
                CFG_SINK:       sink_next       = cfg_data[NODE_W-1:0];
                default:        ;
            endcase
        end

        case (op)
            OP_TAKE_WR:
            begin
                if ((int'(from_node) < MAX_NODES) && (int'(to_node) < MAX_NODES))
                begin
                    cap_we      = 1'b1;
                    cap_wr_addr = mat_addr(IDX_W'(from_node), IDX_W'(to_node));
                    cap_wr_data = CAP_BITS'(capacity);
                end
            end
            OP_TAKE_RUN:
            begin
                n_next       = n_eff;
                src_next     = IDX_W'(source_reg);
                dst_next     = IDX_W'(sink_reg);
                run_ok_next  = run_ok_c;
                total_next   = '0;
                clr_cnt_next = '0;
            end
            OP_CLR_CAP:
            begin
                cap_we       = 1'b1;
                cap_wr_addr  = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            OP_CLR_FLOW:
            begin
                flow_we      = 1'b1;
                flow_wr_addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            OP_BFS_INIT:
            begin
                lv_next          = '0;
                lv_next[src_reg] = 1'b1;
                q_we             = 1'b1;
                q_wr_data        = src_reg;
                lvl_we           = 1'b1;
                lvl_wr_addr      = src_reg;
                head_next        = '0;
                tail_next        = CNT_W'(1);
            end
            OP_BFS_POP:
            begin
                q_rd_addr = head_reg[IDX_W-1:0];
                head_next = head_reg + CNT_W'(1);
            end
            OP_BFS_LVL:
            begin
                cur_v_next  = queue_rd_reg;
                lvl_rd_addr = queue_rd_reg;
            end
            OP_BFS_LVW:
            begin
                cur_lvl_next = level_rd_reg;
                cur_nx_next  = '0;
            end
            OP_BFS_RD:
            begin
                mat_rd_addr = mat_addr(cur_v_reg, cur_idx);
            end
            OP_BFS_EV:
            begin
                if (!lv_reg[cur_idx] && res_pos && (tail_reg < n_reg))
                begin
                    lv_next[cur_idx] = 1'b1;
                    lvl_we           = 1'b1;
                    lvl_wr_addr      = cur_idx;
                    lvl_wr_data      = lvl_plus[IDX_W-1:0];
                    q_we             = 1'b1;
                    q_wr_addr        = tail_reg[IDX_W-1:0];
                    q_wr_data        = cur_idx;
                    tail_next        = tail_reg + CNT_W'(1);
                end
                cur_nx_next = cur_nx_reg + CNT_W'(1);
            end
            OP_NX_START:
            begin
                clr_cnt_next = '0;
            end
            OP_NX_CLR:
            begin
                nx_we        = 1'b1;
                nx_wr_addr   = clr_cnt_reg[IDX_W-1:0];
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            OP_AUG_INIT:
            begin
                depth_next   = '0;
                bi_next      = '0;
                stk_we       = 1'b1;
                stk_wr_data  = src_reg;
                cur_v_next   = src_reg;
                cur_lvl_next = '0;
                nx_rd_addr   = src_reg;
            end
            OP_AUG_NX:
            begin
                cur_nx_next = next_rd_reg;
            end
            OP_AUG_SCAN:
            begin
                mat_rd_addr = mat_addr(cur_v_reg, cur_idx);
                lvl_rd_addr = cur_idx;
            end
            OP_AUG_SKIP:
            begin
                cur_nx_next = cur_nx_reg + CNT_W'(1);
            end
            OP_PUSH:
            begin
                nx_we        = 1'b1;
                nx_wr_addr   = cur_v_reg;
                nx_wr_data   = cur_nx_reg;
                stk_we       = 1'b1;
                stk_wr_addr  = depth_reg + IDX_W'(1);
                stk_wr_data  = cur_idx;
                depth_next   = depth_reg + IDX_W'(1);
                cur_v_next   = cur_idx;
                cur_lvl_next = lvl_plus[IDX_W-1:0];
                nx_rd_addr   = cur_idx;
            end
            OP_POP:
            begin
                nx_we      = 1'b1;
                nx_wr_addr = cur_v_reg;
                nx_wr_data = cur_nx_reg;
                if (depth_reg != '0)
                begin
                    depth_next   = depth_reg - IDX_W'(1);
                    stk_rd_addr  = depth_reg - IDX_W'(1);
                    cur_lvl_next = cur_lvl_reg - IDX_W'(1);
                end
            end
            OP_POPV:
            begin
                cur_v_next = stack_rd_reg;
                nx_rd_addr = stack_rd_reg;
            end
            OP_POPN:
            begin
                cur_nx_next = next_rd_reg + CNT_W'(1);
            end
            OP_BN_INIT:
            begin
                b_next      = CAP_MAX;
                stk_rd_addr = '0;
            end
            OP_BN_A, OP_UP_A:
            begin
                a_next      = stack_rd_reg;
                bi_next     = IDX_W'(1);
                stk_rd_addr = IDX_W'(1);
            end
            OP_BN_C, OP_UP_C:
            begin
                c_next      = stack_rd_reg;
                mat_rd_addr = mat_addr(a_reg, stack_rd_reg);
            end
            OP_BN_R:
            begin
                if (res < $signed({2'b00, b_reg}))
                begin
                    b_next = res[CAP_BITS-1:0];
                end
                a_next = c_reg;
                if (bi_reg != depth_reg)
                begin
                    bi_next     = bi_reg + IDX_W'(1);
                    stk_rd_addr = bi_reg + IDX_W'(1);
                end
            end
            OP_UP_INIT:
            begin
                stk_rd_addr = '0;
            end
            OP_UP_W1:
            begin
                flow_we      = 1'b1;
                flow_wr_addr = mat_addr(a_reg, c_reg);
                flow_wr_data = flow_rd_reg + $signed({1'b0, b_reg});
                mat_rd_addr  = mat_addr(c_reg, a_reg);
            end
            OP_UP_W2:
            begin
                flow_we      = 1'b1;
                flow_wr_addr = mat_addr(c_reg, a_reg);
                flow_wr_data = flow_rd_reg - $signed({1'b0, b_reg});
                a_next       = c_reg;
                if (bi_reg != depth_reg)
                begin
                    bi_next     = bi_reg + IDX_W'(1);
                    stk_rd_addr = bi_reg + IDX_W'(1);
                end
            end
            OP_ACC:
            begin
                if (sum > TOT_W'(FLOW_OUT_MAX))
                begin
                    total_next = FLOW_OUT_MAX;
                end
                else
                begin
                    total_next = sum[FLOW_OUT_W-1:0];
                end
            end
            OP_RESULT:
            begin
                out_data_next  = total_reg;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= RST_NODE_COUNT;
            source_reg     <= RST_SOURCE;
            sink_reg       <= RST_SINK;
            run_ok_reg     <= 1'b0;
            clr_cnt_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            cur_nx_reg     <= '0;
            depth_reg      <= '0;
            bi_reg         <= '0;
            lv_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            source_reg     <= source_next;
            sink_reg       <= sink_next;
            run_ok_reg     <= run_ok_next;
            clr_cnt_reg    <= clr_cnt_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cur_nx_reg     <= cur_nx_next;
            depth_reg      <= depth_next;
            bi_reg         <= bi_next;
            lv_reg         <= lv_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        cur_v_reg    <= cur_v_next;
        cur_lvl_reg  <= cur_lvl_next;
        a_reg        <= a_next;
        c_reg        <= c_next;
        b_reg        <= b_next;
        total_reg    <= total_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (cap_we)
        begin
            cap_mem[cap_wr_addr] <= cap_wr_data;
        end
        cap_rd_reg <= cap_mem[mat_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (flow_we)
        begin
            flow_mem[flow_wr_addr] <= flow_wr_data;
        end
        flow_rd_reg <= flow_mem[mat_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            level_mem[lvl_wr_addr] <= lvl_wr_data;
        end
        level_rd_reg <= level_mem[lvl_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_wr_addr] <= nx_wr_data;
        end
        next_rd_reg <= next_mem[nx_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_wr_addr] <= q_wr_data;
        end
        queue_rd_reg <= queue_mem[q_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_wr_addr] <= stk_wr_data;
        end
        stack_rd_reg <= stack_mem[stk_rd_addr];
    end

endmodule

// ----- src/max_flow_level_graph.sv -----
// ----------------------------------------------------------------------------
// max_flow_level_graph
// Level-graph maximum flow engine over a dense capacity matrix. Write
// transfers store one capacity entry; a compute transfer returns the total
// flow from source to sink.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   req_type, from_node, to_node,
//                                              capacity
//   output    out        out_valid / out_stall max_flow
//   config    in         cfg_write             cfg_index, cfg_data
//
// A compute clears the flow matrix, then alternates level searches over
// probed matrix entries with path searches over probed neighbors, all
// through the single read port of the matrix memories.
// After reset the capacity matrix is cleared, during which no input
// transfer is taken. A stalled result waits in the output register; write
// transfers are still taken meanwhile.
module max_flow_level_graph #(
    parameter int MAX_NODES = mfl_pkg::DEF_MAX_NODES,
    parameter int CAP_BITS  = mfl_pkg::DEF_CAP_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           req_type,
    input  logic [mfl_pkg::NODE_W-1:0]     from_node,
    input  logic [mfl_pkg::NODE_W-1:0]     to_node,
    input  logic [mfl_pkg::CAP_IN_W-1:0]   capacity,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mfl_pkg::FLOW_OUT_W-1:0] max_flow,
    input  logic                           cfg_write,
    input  logic [mfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mfl_pkg::*;

    op_t     op;
    status_t status;

    mfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .status   (status),
        .op       (op),
        .in_stall (in_stall)
    );

    mfl_datapath #(
        .MAX_NODES (MAX_NODES),
        .CAP_BITS  (CAP_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .from_node (from_node),
        .to_node   (to_node),
        .capacity  (capacity),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .max_flow  (max_flow)
    );

endmodule
